// ===== rtl/wvt_pkg.sv =====
package wvt_pkg;

  localparam int WVT_MAX_WAYPOINTS = 64;
  localparam int WVT_CORDIC_STEPS  = 14;
  localparam int MUL_STEPS         = 8;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_POSE = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;
  localparam logic [1:0] ACT_ARM  = 2'd3;

  localparam logic [2:0] REG_WAYPOINT_COUNT = 3'd0;
  localparam logic [2:0] REG_GAIN_XY        = 3'd1;
  localparam logic [2:0] REG_GAIN_Z         = 3'd2;
  localparam logic [2:0] REG_SPEED_LIMIT_XY = 3'd3;
  localparam logic [2:0] REG_SPEED_LIMIT_Z  = 3'd4;
  localparam logic [2:0] REG_ARRIVE_RADIUS  = 3'd5;
  localparam logic [2:0] REG_GAIN_YAW       = 3'd6;
  localparam logic [2:0] REG_YAW_RATE_LIMIT = 3'd7;

  localparam logic [6:0]  RST_WAYPOINT_COUNT = 7'd0;
  localparam logic [15:0] RST_GAIN_XY        = 16'd128;
  localparam logic [15:0] RST_GAIN_Z         = 16'd128;
  localparam logic [23:0] RST_SPEED_LIMIT_XY = 24'd65536;
  localparam logic [23:0] RST_SPEED_LIMIT_Z  = 24'd32768;
  localparam logic [23:0] RST_ARRIVE_RADIUS  = 24'd13107;
  localparam logic [15:0] RST_GAIN_YAW       = 16'd256;
  localparam logic [14:0] RST_YAW_RATE_LIMIT = 15'd4096;

  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

  localparam logic signed [17:0] ATAN_TAB [24] = '{
    18'sd6434, 18'sd3798, 18'sd2007, 18'sd1019, 18'sd511, 18'sd256, 18'sd128, 18'sd64,
    18'sd32, 18'sd16, 18'sd8, 18'sd4, 18'sd2, 18'sd1, 18'sd0, 18'sd0,
    18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0
  };

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_WRITE,
    OP_QMUL,
    OP_CINIT,
    OP_CROT,
    OP_PCOMMIT,
    OP_TREAD,
    OP_TDIFF,
    OP_TMUL,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       start_latch;
    logic       engaged;
    logic       hold_zero;
    logic [6:0] index;
    logic [6:0] target;
    logic       phase;
    logic       done;
  } cmd_t;

  typedef struct packed {
    logic       arrived;
    logic [6:0] count;
  } status_t;

endpackage

// ===== rtl/waypoint_velocity_tracker_top.sv =====
// A ready tick reads the table, forms differences, runs the shared multiplier
// (8 steps) and decides; a tick that is not ready gives a zero result, a pose
// runs the multiplier and the CORDIC loop and a load writes the table. No new
// item is taken until any result is accepted (out_stall low) and the
// controller is idle again. Reset is synchronous and active high; it
// restores register defaults and sequencing state but not the waypoint table.
module waypoint_velocity_tracker_top #(
  parameter int MAX_WAYPOINTS = wvt_pkg::WVT_MAX_WAYPOINTS,
  parameter int CORDIC_STEPS  = wvt_pkg::WVT_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [5:0]         slot,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [24:0] vel_x,
  output logic signed [24:0] vel_y,
  output logic signed [24:0] vel_z,
  output logic signed [15:0] yaw_rate,
  output logic [6:0]         target_slot,
  output logic               phase,
  output logic               final_done,
  output logic               engaged
);
  import wvt_pkg::*;

  localparam int SW = $clog2((CORDIC_STEPS > MUL_STEPS) ? CORDIC_STEPS : MUL_STEPS);

  cmd_t cmd;
  status_t status;
  logic [SW-1:0] step;

  wvt_ctrl #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS),
    .CORDIC_STEPS(CORDIC_STEPS),
    .SW(SW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .cmd(cmd),
    .step(step)
  );

  wvt_datapath #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS),
    .SW(SW)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .step(step),
    .status(status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .slot(slot),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .coord_z(coord_z),
    .quat_w(quat_w),
    .quat_x(quat_x),
    .quat_y(quat_y),
    .quat_z(quat_z),
    .vel_x(vel_x),
    .vel_y(vel_y),
    .vel_z(vel_z),
    .yaw_rate(yaw_rate),
    .target_slot(target_slot),
    .phase(phase),
    .final_done(final_done),
    .engaged(engaged)
  );

  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("item accepted while a result is pending");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !engaged) |-> (vel_x == 25'sd0 && vel_y == 25'sd0 &&
                                 vel_z == 25'sd0 && yaw_rate == 16'sd0))
    else $error("non-zero command while not engaged");

  a_done_implies_moving: assert property (@(posedge clk) disable iff (rst)
    (out_valid && final_done) |-> phase) else $error("final hold outside moving phase");

endmodule

// ===== rtl/wvt_ctrl.sv =====
module wvt_ctrl #(
  parameter int MAX_WAYPOINTS = wvt_pkg::WVT_MAX_WAYPOINTS,
  parameter int CORDIC_STEPS  = wvt_pkg::WVT_CORDIC_STEPS,
  parameter int SW            = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  output logic              out_valid,
  input  logic              out_stall,
  input  wvt_pkg::status_t  status,
  output wvt_pkg::cmd_t     cmd,
  output logic [SW-1:0]     step
);
  import wvt_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_LOAD    = 12'b000000000010,
    S_QMUL    = 12'b000000000100,
    S_CINIT   = 12'b000000001000,
    S_CROT    = 12'b000000010000,
    S_PCOMMIT = 12'b000000100000,
    S_TREAD   = 12'b000001000000,
    S_TDIFF   = 12'b000010000000,
    S_TMUL    = 12'b000100000000,
    S_TDECIDE = 12'b001000000000,
    S_TZERO   = 12'b010000000000,
    S_OUT     = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic [SW-1:0] step_next;
  logic armed, armed_next, pose_seen, pose_seen_next, start_seen, start_seen_next;
  logic phase_r, phase_next, done_r, done_next;
  logic [6:0] idx, idx_next, n, nm1, t;
  logic hold;
  logic ready;

  assign n = (32'(status.count) < MAX_WAYPOINTS) ? status.count : 7'(MAX_WAYPOINTS);
  assign nm1 = n - 7'd1;
  assign t = (idx < nm1) ? idx : nm1;
  assign ready = armed && pose_seen && start_seen && (n != 7'd0);
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    step_next = step;
    armed_next = armed;
    pose_seen_next = pose_seen;
    start_seen_next = start_seen;
    phase_next = phase_r;
    done_next = done_r;
    idx_next = idx;
    hold = 1'b0;
    cmd.op = OP_NONE;
    cmd.start_latch = !start_seen;
    cmd.engaged = 1'b0;
    cmd.hold_zero = 1'b0;
    cmd.index = idx;
    cmd.target = t;
    cmd.phase = phase_r;
    cmd.done = done_r;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LATCH;
          step_next = '0;
          case (action)
            ACT_LOAD: state_next = S_LOAD;
            ACT_POSE: state_next = S_QMUL;
            ACT_TICK: state_next = ready ? S_TREAD : S_TZERO;
            ACT_ARM:  armed_next = 1'b1;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.op = OP_WRITE;
        state_next = S_IDLE;
      end
      S_QMUL: begin
        cmd.op = OP_QMUL;
        if (step == SW'(MUL_STEPS - 1)) begin
          state_next = S_CINIT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_CINIT: begin
        cmd.op = OP_CINIT;
        step_next = '0;
        state_next = S_CROT;
      end
      S_CROT: begin
        cmd.op = OP_CROT;
        if (step == SW'(CORDIC_STEPS - 1)) begin
          state_next = S_PCOMMIT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_PCOMMIT: begin
        cmd.op = OP_PCOMMIT;
        pose_seen_next = 1'b1;
        start_seen_next = 1'b1;
        state_next = S_IDLE;
      end
      S_TREAD: begin
        cmd.op = OP_TREAD;
        state_next = S_TDIFF;
      end
      S_TDIFF: begin
        cmd.op = OP_TDIFF;
        step_next = '0;
        state_next = S_TMUL;
      end
      S_TMUL: begin
        cmd.op = OP_TMUL;
        if (step == SW'(MUL_STEPS - 1)) begin
          state_next = S_TDECIDE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_TDECIDE: begin
        if (!phase_r) begin
          if (status.arrived) begin
            phase_next = 1'b1;
            if (idx < nm1) begin
              idx_next = idx + 7'd1;
            end
          end
        end else if (status.arrived) begin
          if (idx < nm1) begin
            idx_next = idx + 7'd1;
            hold = 1'b1;
          end else if (!done_r) begin
            done_next = 1'b1;
            idx_next = n;
          end
        end
        cmd.op = OP_OUT;
        cmd.engaged = 1'b1;
        cmd.hold_zero = hold;
        cmd.index = idx_next;
        cmd.phase = phase_next;
        cmd.done = done_next;
        state_next = S_OUT;
      end
      S_TZERO: begin
        cmd.op = OP_OUT;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      armed <= 1'b0;
      pose_seen <= 1'b0;
      start_seen <= 1'b0;
      phase_r <= 1'b0;
      done_r <= 1'b0;
      idx <= 7'd0;
    end else begin
      state <= state_next;
      step <= step_next;
      armed <= armed_next;
      pose_seen <= pose_seen_next;
      start_seen <= start_seen_next;
      phase_r <= phase_next;
      done_r <= done_next;
      idx <= idx_next;
    end
  end

endmodule

// ===== rtl/wvt_datapath.sv =====
module wvt_datapath #(
  parameter int MAX_WAYPOINTS = wvt_pkg::WVT_MAX_WAYPOINTS,
  parameter int SW            = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  wvt_pkg::cmd_t       cmd,
  input  logic [SW-1:0]       step,
  output wvt_pkg::status_t    status,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic [5:0]          slot,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic signed [31:0]  coord_z,
  input  logic signed [15:0]  quat_w,
  input  logic signed [15:0]  quat_x,
  input  logic signed [15:0]  quat_y,
  input  logic signed [15:0]  quat_z,
  output logic signed [24:0]  vel_x,
  output logic signed [24:0]  vel_y,
  output logic signed [24:0]  vel_z,
  output logic signed [15:0]  yaw_rate,
  output logic [6:0]          target_slot,
  output logic                phase,
  output logic                final_done,
  output logic                engaged
);
  import wvt_pkg::*;

  localparam int AW = $clog2(MAX_WAYPOINTS);

  logic [6:0]  waypoint_count;
  logic [15:0] gain_xy, gain_z, gain_yaw;
  logic [23:0] speed_limit_xy, speed_limit_z, arrive_radius;
  logic [14:0] yaw_rate_limit;

  logic signed [31:0] mem_x [MAX_WAYPOINTS];
  logic signed [31:0] mem_y [MAX_WAYPOINTS];
  logic signed [31:0] mem_z [MAX_WAYPOINTS];

  logic [5:0] slot_l;
  logic signed [31:0] cx_l, cy_l, cz_l;
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] pose_x, pose_y, pose_z, rd_x, rd_y, rd_z;
  logic signed [15:0] heading, start_heading;
  logic signed [34:0] d_acc, den_acc, g_acc, nm_acc;
  logic signed [43:0] cx, cy;
  logic signed [17:0] ang;
  logic sing;
  logic signed [32:0] dx, dy, dz;
  logic near;
  logic signed [16:0] err;
  logic signed [24:0] vx, vy, vz;
  logic signed [15:0] yr;
  logic [50:0] sq;
  logic [47:0] rr;

  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] prod, shifted;
  logic signed [34:0] p35, g_abs;
  logic signed [43:0] cx0, cy0, sx, sy;
  logic signed [17:0] ang_w;
  logic signed [16:0] e_raw, e_w;
  logic signed [32:0] dx_n, dy_n, dz_n;

  function automatic logic signed [32:0] ext_a(input logic signed [15:0] v);
    ext_a = {{17{v[15]}}, v};
  endfunction

  function automatic logic signed [24:0] ext_b(input logic signed [15:0] v);
    ext_b = {{9{v[15]}}, v};
  endfunction

  function automatic logic signed [24:0] clamp(input logic signed [57:0] v,
                                               input logic [23:0] lim);
    logic signed [57:0] l, nl;
    l = {34'd0, lim};
    nl = -l;
    if (v > l) begin
      clamp = l[24:0];
    end else if (v < nl) begin
      clamp = nl[24:0];
    end else begin
      clamp = v[24:0];
    end
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_QMUL: begin
        case (step)
          SW'(0): begin mul_a = ext_a(qw); mul_b = ext_b(qw); end
          SW'(1): begin mul_a = ext_a(qx); mul_b = ext_b(qx); end
          SW'(2): begin mul_a = ext_a(qy); mul_b = ext_b(qy); end
          SW'(3): begin mul_a = ext_a(qz); mul_b = ext_b(qz); end
          SW'(4): begin mul_a = ext_a(qx); mul_b = ext_b(qz); end
          SW'(5): begin mul_a = ext_a(qw); mul_b = ext_b(qy); end
          SW'(6): begin mul_a = ext_a(qx); mul_b = ext_b(qy); end
          SW'(7): begin mul_a = ext_a(qw); mul_b = ext_b(qz); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      OP_TMUL: begin
        case (step)
          SW'(0): begin mul_a = {{16{err[16]}}, err}; mul_b = {9'd0, gain_yaw}; end
          SW'(1): begin mul_a = dx; mul_b = {9'd0, gain_xy}; end
          SW'(2): begin mul_a = dy; mul_b = {9'd0, gain_xy}; end
          SW'(3): begin mul_a = dz; mul_b = {9'd0, gain_z}; end
          SW'(4): begin mul_a = dx; mul_b = dx[24:0]; end
          SW'(5): begin mul_a = dy; mul_b = dy[24:0]; end
          SW'(6): begin mul_a = dz; mul_b = dz[24:0]; end
          SW'(7): begin mul_a = {9'd0, arrive_radius}; mul_b = {1'b0, arrive_radius}; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign shifted = prod >>> 8;
  assign p35 = prod[34:0];
  assign g_abs = g_acc[34] ? -g_acc : g_acc;
  assign cx0 = {den_acc[34], den_acc, 8'd0};
  assign cy0 = {nm_acc, 9'd0};
  assign sx = cx >>> step;
  assign sy = cy >>> step;
  assign ang_w = (ang > PI_Q13) ? ang - TWO_PI_Q13 :
                 (ang < -PI_Q13) ? ang + TWO_PI_Q13 : ang;
  assign e_raw = {start_heading[15], start_heading} - {heading[15], heading};
  assign e_w = (e_raw > 17'(PI_Q13)) ? e_raw - 17'(TWO_PI_Q13) :
               (e_raw < -17'(PI_Q13)) ? e_raw + 17'(TWO_PI_Q13) : e_raw;
  assign dx_n = {rd_x[31], rd_x} - {pose_x[31], pose_x};
  assign dy_n = {rd_y[31], rd_y} - {pose_y[31], pose_y};
  assign dz_n = {rd_z[31], rd_z} - {pose_z[31], pose_z};

  assign status.arrived = near && (sq < {3'd0, rr});
  assign status.count = waypoint_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_count <= RST_WAYPOINT_COUNT;
      gain_xy <= RST_GAIN_XY;
      gain_z <= RST_GAIN_Z;
      speed_limit_xy <= RST_SPEED_LIMIT_XY;
      speed_limit_z <= RST_SPEED_LIMIT_Z;
      arrive_radius <= RST_ARRIVE_RADIUS;
      gain_yaw <= RST_GAIN_YAW;
      yaw_rate_limit <= RST_YAW_RATE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAYPOINT_COUNT: waypoint_count <= cfg_data[6:0];
        REG_GAIN_XY:        gain_xy <= cfg_data[15:0];
        REG_GAIN_Z:         gain_z <= cfg_data[15:0];
        REG_SPEED_LIMIT_XY: speed_limit_xy <= cfg_data;
        REG_SPEED_LIMIT_Z:  speed_limit_z <= cfg_data;
        REG_ARRIVE_RADIUS:  arrive_radius <= cfg_data;
        REG_GAIN_YAW:       gain_yaw <= cfg_data[15:0];
        REG_YAW_RATE_LIMIT: yaw_rate_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && 32'(slot_l) < MAX_WAYPOINTS) begin
      mem_x[AW'(slot_l)] <= cx_l;
      mem_y[AW'(slot_l)] <= cy_l;
      mem_z[AW'(slot_l)] <= cz_l;
    end
    if (cmd.op == OP_TREAD) begin
      rd_x <= mem_x[AW'(cmd.target)];
      rd_y <= mem_y[AW'(cmd.target)];
      rd_z <= mem_z[AW'(cmd.target)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x <= '0;
      pose_y <= '0;
      pose_z <= '0;
      heading <= '0;
      start_heading <= '0;
    end else begin
      case (cmd.op)
        OP_LATCH: begin
          slot_l <= slot;
          cx_l <= coord_x;
          cy_l <= coord_y;
          cz_l <= coord_z;
          qw <= quat_w;
          qx <= quat_x;
          qy <= quat_y;
          qz <= quat_z;
        end
        OP_QMUL: begin
          case (step)
            SW'(0): begin d_acc <= p35; den_acc <= p35; end
            SW'(1): begin d_acc <= d_acc + p35; den_acc <= den_acc + p35; end
            SW'(2): begin d_acc <= d_acc + p35; den_acc <= den_acc - p35; end
            SW'(3): begin d_acc <= d_acc + p35; den_acc <= den_acc - p35; end
            SW'(4): g_acc <= p35;
            SW'(5): g_acc <= g_acc - p35;
            SW'(6): nm_acc <= p35;
            SW'(7): nm_acc <= nm_acc + p35;
            default: ;
          endcase
        end
        OP_CINIT: begin
          sing <= ({g_abs, 1'b0} >= {d_acc[34], d_acc});
          if (den_acc[34]) begin
            cx <= -cx0;
            cy <= -cy0;
            ang <= nm_acc[34] ? -PI_Q13 : PI_Q13;
          end else begin
            cx <= cx0;
            cy <= cy0;
            ang <= '0;
          end
        end
        OP_CROT: begin
          if (cy > 44'sd0) begin
            cx <= cx + sy;
            cy <= cy - sx;
            ang <= ang + ATAN_TAB[5'(step)];
          end else begin
            cx <= cx - sy;
            cy <= cy + sx;
            ang <= ang - ATAN_TAB[5'(step)];
          end
        end
        OP_PCOMMIT: begin
          pose_x <= cx_l;
          pose_y <= cy_l;
          pose_z <= cz_l;
          heading <= sing ? 16'sd0 : 16'(ang_w);
          if (cmd.start_latch) begin
            start_heading <= sing ? 16'sd0 : 16'(ang_w);
          end
        end
        OP_TDIFF: begin
          dx <= dx_n;
          dy <= dy_n;
          dz <= dz_n;
          near <= (dx_n < 33'sd16777216) && (dx_n > -33'sd16777216) &&
                  (dy_n < 33'sd16777216) && (dy_n > -33'sd16777216) &&
                  (dz_n < 33'sd16777216) && (dz_n > -33'sd16777216);
          err <= e_w;
        end
        OP_TMUL: begin
          case (step)
            SW'(0): yr <= 16'(clamp(shifted, {9'd0, yaw_rate_limit}));
            SW'(1): vx <= clamp(shifted, speed_limit_xy);
            SW'(2): vy <= clamp(shifted, speed_limit_xy);
            SW'(3): vz <= clamp(shifted, speed_limit_z);
            SW'(4): sq <= prod[50:0];
            SW'(5): sq <= sq + prod[50:0];
            SW'(6): sq <= sq + prod[50:0];
            SW'(7): rr <= prod[47:0];
            default: ;
          endcase
        end
        OP_OUT: begin
          vel_x <= (cmd.engaged && !cmd.hold_zero) ? vx : 25'sd0;
          vel_y <= (cmd.engaged && !cmd.hold_zero) ? vy : 25'sd0;
          vel_z <= (cmd.engaged && !cmd.hold_zero) ? vz : 25'sd0;
          yaw_rate <= cmd.engaged ? yr : 16'sd0;
          target_slot <= cmd.index;
          phase <= cmd.phase;
          final_done <= cmd.done;
          engaged <= cmd.engaged;
        end
        default: ;
      endcase
    end
  end

endmodule
